@@ hw/rtl/arqrr_pkg.sv @@
// Package for the ARQ receive reorder and status block: defaults, field widths and codes.
`timescale 1ns / 1ps
`default_nettype none

package arqrr_pkg;

	// Default window size and sequence number width.
	localparam int WINDOW_DEF   = 32;
	localparam int SEQ_BITS_DEF = 12;

	// Fixed field widths on the stream ports.
	localparam int SEQ_FIELD_W = 12;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;
	localparam int KIND_W      = 3;

	// Input operation codes carried in tuser.
	localparam logic OP_DATA   = 1'b0;
	localparam logic OP_STATUS = 1'b1;

	// Result kinds carried in tuser.
	typedef enum logic [KIND_W-1:0] {
		KIND_DELIVERED = 3'd0,
		KIND_DONE      = 3'd1,
		KIND_DROPPED   = 3'd2,
		KIND_ACK       = 3'd3,
		KIND_MISSING   = 3'd4
	} kind_t;

endpackage

`default_nettype wire

@@ hw/rtl/arq_receive_reorder_status.sv @@
// Data: evaluate marks or drops the word; deliver sends the run, d words (0 to WINDOW), and done.
// Status: evaluate sends the ack; the status state then scans the span for missing numbers.
// One word is worked on at a time; one shared sequence adder is stepped by the sequencer.
// The output register lets the last result wait while the next input word is taken.
// Reset (arst_n low, asynchronous) clears the received map, next-expected and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module arq_receive_reorder_status
	import arqrr_pkg::*;
#(
	parameter int WINDOW   = WINDOW_DEF,
	parameter int SEQ_BITS = SEQ_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// seq_num [11:0], poll_flag [12], status_end [24:13], zero [31:25]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// opcode [0]
	input  wire logic [0:0]             s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// out_seq [11:0], poll_seen [12], zero [15:13]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// kind [2:0]
	output logic [KIND_W-1:0]           m_axis_tuser,
	output logic                        m_axis_tlast
);

	localparam int IDXW = $clog2(WINDOW);
	localparam int CNTW = $clog2(WINDOW + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DELIVER,
		ST_STATUS
	} state_t;

	state_t                state_q;
	logic                  opcode_q;
	logic [SEQ_BITS-1:0]   seq_q;
	logic                  poll_q;
	logic [SEQ_BITS-1:0]   end_q;
	logic [SEQ_BITS-1:0]   next_q;
	logic [SEQ_BITS-1:0]   cur_q;
	logic [WINDOW-1:0]     map_q;
	logic [WINDOW-1:0]     scan_q;
	logic [CNTW-1:0]       cnt_q;

	logic                  out_valid_q;
	kind_t                 out_kind_q;
	logic [SEQ_FIELD_W-1:0] out_seq_q;
	logic                  out_poll_q;
	logic                  out_last_q;

	logic [SEQ_BITS-1:0]   op_a;
	logic [SEQ_BITS-1:0]   op_b;
	logic [SEQ_BITS-1:0]   sum;
	logic                  in_win;
	logic [CNTW-1:0]       span_cnt;
	logic [CNTW-1:0]       cnt_sel;
	logic [WINDOW-1:0]     mask;
	logic                  any_miss;
	logic                  more_miss;
	logic                  out_free;

	logic                  emit;
	kind_t                 e_kind;
	logic [SEQ_BITS-1:0]   e_seq;
	logic                  e_poll;
	logic                  e_last;

	// The output register is free when empty or when its word is taken this cycle.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// Shared sequence adder: distance from next-expected, or an increment by one.
	always_comb begin
		op_a = cur_q;
		op_b = '0;
		unique case (state_q)
			ST_EVAL: begin
				op_a = (opcode_q == OP_STATUS) ? end_q : seq_q;
				op_b = ~next_q;
			end
			ST_DELIVER: begin
				op_a = next_q;
			end
			default: begin
			end
		endcase
		sum = op_a + op_b + SEQ_BITS'(1);
	end

	// Window test and clamped status span, both taken from the adder's distance.
	assign in_win   = (sum < SEQ_BITS'(WINDOW));
	assign span_cnt = (sum > SEQ_BITS'(WINDOW)) ? CNTW'(WINDOW) : CNTW'(sum);
	assign cnt_sel  = (state_q == ST_EVAL) ? span_cnt : cnt_q;

	// Positions still inside the span, and whether any missing number lies in them.
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			mask[i] = (CNTW'(i) < cnt_sel);
		end
	end

	assign any_miss  = |(~map_q & mask);
	assign more_miss = |(~scan_q[WINDOW-1:1] & mask[WINDOW-1:1]);

	// Result chosen for this cycle, if any.
	always_comb begin
		emit   = 1'b0;
		e_kind = KIND_DELIVERED;
		e_seq  = next_q;
		e_poll = 1'b0;
		e_last = 1'b0;
		unique case (state_q)
			ST_EVAL: begin
				if (opcode_q == OP_STATUS) begin
					emit   = 1'b1;
					e_kind = KIND_ACK;
					e_last = !any_miss;
				end else if (!in_win) begin
					emit   = 1'b1;
					e_kind = KIND_DROPPED;
					e_seq  = seq_q;
					e_poll = poll_q;
					e_last = 1'b1;
				end
			end
			ST_DELIVER: begin
				emit = 1'b1;
				if (!map_q[0]) begin
					e_kind = KIND_DONE;
					e_poll = poll_q;
					e_last = 1'b1;
				end
			end
			ST_STATUS: begin
				emit   = !scan_q[0];
				e_kind = KIND_MISSING;
				e_seq  = cur_q;
				e_last = !more_miss;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, window state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_q      <= '0;
			map_q       <= '0;
			out_valid_q <= 1'b0;
			opcode_q    <= OP_DATA;
			seq_q       <= '0;
			poll_q      <= 1'b0;
			end_q       <= '0;
			cur_q       <= '0;
			scan_q      <= '0;
			cnt_q       <= '0;
			out_kind_q  <= KIND_DELIVERED;
			out_seq_q   <= '0;
			out_poll_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit && out_free) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= e_kind;
				out_seq_q   <= SEQ_FIELD_W'(e_seq);
				out_poll_q  <= e_poll;
				out_last_q  <= e_last;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						opcode_q <= s_axis_tuser[0];
						seq_q    <= SEQ_BITS'(s_axis_tdata[11:0]);
						poll_q   <= s_axis_tdata[12];
						end_q    <= SEQ_BITS'(s_axis_tdata[24:13]);
						state_q  <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (opcode_q == OP_STATUS) begin
						if (out_free) begin
							scan_q  <= map_q;
							cnt_q   <= span_cnt;
							cur_q   <= next_q;
							state_q <= any_miss ? ST_STATUS : ST_IDLE;
						end
					end else if (in_win) begin
						map_q[IDXW'(sum)] <= 1'b1;
						state_q           <= ST_DELIVER;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DELIVER: begin
					if (out_free) begin
						if (map_q[0]) begin
							map_q  <= {1'b0, map_q[WINDOW-1:1]};
							next_q <= sum;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STATUS: begin
					if (scan_q[0] || out_free) begin
						scan_q <= {1'b0, scan_q[WINDOW-1:1]};
						cnt_q  <= cnt_q - CNTW'(1);
						cur_q  <= sum;
						if (!scan_q[0] && !more_miss) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_poll_q, out_seq_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// Next-expected only moves while an in-order run is being delivered.
	a_next_only_in_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> $stable(next_q))
		else $error("next-expected changed outside delivery");

	// Between words the entry for next-expected is never left marked.
	a_head_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !map_q[0])
		else $error("head of received map set while idle");

	// The status scan never runs past the end of its span.
	a_scan_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STATUS) |-> (cnt_q != '0))
		else $error("status scan ran past its span");

	// A status scan leaves the received map untouched.
	a_map_stable_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STATUS) |=> $stable(map_q))
		else $error("received map changed during status scan");

endmodule

`default_nettype wire
